@@ design/prp_pkg.sv @@
// Shared constants, types and state codes of the page replacement block.
package prp_pkg;

  // Table geometry and field widths
  localparam int PAGES   = 64;
  localparam int PAGE_W  = 6;
  localparam int CNT_W   = PAGE_W + 1;
  localparam int FRAME_W = 8;
  localparam int STAMP_W = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CNT_W-1:0] PAGES_CNT = CNT_W'(PAGES);

  // Register index, taken from the word address bit of paddr
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_PAGES = 1'b1;

  // Item kinds and policy modes
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_VICTIM = 1'b1;
  localparam logic MODE_CLOCK  = 1'b0;
  localparam logic MODE_LRU    = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLK_SCAN,
    ST_LRU_SCAN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Write request into the stamp and frame memories
  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  addr;
    logic [STAMP_W-1:0] stamp;
    logic [FRAME_W-1:0] frame;
  } store_wr_t;

endpackage

@@ design/prp_store.sv @@
// Stamp and frame memories of the page table, one write port, registered reads.
module prp_store import prp_pkg::*; (
  input  logic               clk,
  input  store_wr_t          wr,
  input  logic [PAGE_W-1:0]  stamp_raddr,
  input  logic [PAGE_W-1:0]  frame_raddr,
  output logic [STAMP_W-1:0] stamp_q,
  output logic [FRAME_W-1:0] frame_q
);

  logic [STAMP_W-1:0] stamp_mem [PAGES];
  logic [FRAME_W-1:0] frame_mem [PAGES];
  logic [STAMP_W-1:0] stamp_q_r;
  logic [FRAME_W-1:0] frame_q_r;

  // Both memories are written together on a page access
  always_ff @(posedge clk) begin
    if (wr.we) begin
      stamp_mem[wr.addr] <= wr.stamp;
      frame_mem[wr.addr] <= wr.frame;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    stamp_q_r <= stamp_mem[stamp_raddr];
    frame_q_r <= frame_mem[frame_raddr];
  end

  assign stamp_q = stamp_q_r;
  assign frame_q = frame_q_r;

endmodule

@@ design/page_replacement_policy_top.sv @@
// Page replacement policy top level: sequencer, page state bits, config port, result register.
//
// A page access is accepted in the idle state and written in the same cycle.
// A victim request walks the page entries one per cycle through a single compare unit.
// With n = pages in use, LRU mode scans the n entries with one stamp-memory read and one
// 32-bit compare per entry, then reads the victim's frame and loads the result; clock mode
// makes up to two rounds of a clean pass and a dirty pass from the hand, then the frame read
// and the result load. A search that finds no page skips the frame read. The result load
// waits while the previous result still waits in the output register. The block takes
// no item while a victim search runs; a finished result waits in the output register, and
// the next item is taken meanwhile. Reset clears the page state at once through per-page
// valid bits, so there is no clearing pass after reset.
module page_replacement_policy_top import prp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_number,
  input  logic               in_is_write,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PAGE_W-1:0]  out_victim_page,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic               out_victim_dirty,
  output logic               out_no_victim,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // Configuration registers
  logic              mode_r;
  logic [CNT_W-1:0]  pages_r;

  // Per-page state bits; sval = stamp word valid, unz = stamp word nonzero
  logic [PAGES-1:0]  present_r, present_nxt;
  logic [PAGES-1:0]  modified_r, modified_nxt;
  logic [PAGES-1:0]  sval_r, sval_nxt;
  logic [PAGES-1:0]  unz_r, unz_nxt;

  logic [PAGE_W-1:0]  hand_r, hand_nxt;
  logic [STAMP_W-1:0] stamp_ctr_r, stamp_ctr_nxt;

  // Sequencer and scan registers
  state_t             state_r, state_nxt;
  logic [PAGE_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [1:0]         pass_r, pass_nxt;
  logic               dly_vld_r, dly_vld_nxt;
  logic [PAGE_W-1:0]  dly_idx_r, dly_idx_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic               found_r, found_nxt;
  logic [PAGE_W-1:0]  victim_r, victim_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_dirty_r, out_dirty_nxt;
  logic               out_nov_r, out_nov_nxt;

  // Control strobes
  logic               in_fire, acc_go, vic_go, emit_go;
  logic [CNT_W-1:0]   live_n;
  logic [PAGE_W-1:0]  hand_start;
  logic [CNT_W-1:0]   idx_inc, victim_inc;
  logic               idx_wrap, step_last;
  logic               clk_hit, clk_clear;
  logic               lru_done;
  logic [STAMP_W-1:0] acc_stamp, cand_stamp;
  logic               cand_better;
  store_wr_t          st_wr;
  logic [STAMP_W-1:0] stamp_q;
  logic [FRAME_W-1:0] frame_q;

  // Live page count saturates at the table size
  assign live_n     = (pages_r > PAGES_CNT) ? PAGES_CNT : pages_r;
  assign hand_start = ({1'b0, hand_r} < live_n) ? hand_r : '0;
  assign idx_inc    = {1'b0, idx_r} + CNT_W'(1);
  assign idx_wrap   = (idx_inc == live_n);
  assign victim_inc = {1'b0, victim_r} + CNT_W'(1);
  assign step_last  = (step_r + CNT_W'(1) == live_n);

  // Clock-mode test of the entry under idx: clean pass on even passes, dirty pass on odd
  always_comb begin
    clk_hit   = 1'b0;
    clk_clear = 1'b0;
    if (!pass_r[0]) begin
      clk_hit = present_r[idx_r] & ~modified_r[idx_r] & ~unz_r[idx_r];
    end else begin
      clk_hit   = present_r[idx_r] & modified_r[idx_r] & ~unz_r[idx_r];
      clk_clear = present_r[idx_r] & ~clk_hit;
    end
  end

  // LRU compare unit: stamp of the delayed entry against the best so far
  assign cand_stamp  = sval_r[dly_idx_r] ? stamp_q : '0;
  assign cand_better = dly_vld_r & present_r[dly_idx_r] & (~found_r | (cand_stamp < best_r));
  assign lru_done    = (step_r == live_n) & ~dly_vld_r;

  // Handshake outputs of the sequencer
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    emit_go  = (state_r == ST_EMIT) & (~out_valid_r | out_ready);
  end

  assign in_fire = in_valid & in_ready;
  assign acc_go  = in_fire & (in_kind == KIND_ACCESS) & ({1'b0, in_page_number} < live_n);
  assign vic_go  = in_fire & (in_kind == KIND_VICTIM);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (vic_go) begin
          if (live_n == '0)          state_nxt = ST_EMIT;
          else if (mode_r == MODE_LRU) state_nxt = ST_LRU_SCAN;
          else                         state_nxt = ST_CLK_SCAN;
        end
      end
      ST_CLK_SCAN: begin
        if (clk_hit)                           state_nxt = ST_FETCH;
        else if (step_last && pass_r == 2'd3) state_nxt = ST_EMIT;
      end
      ST_LRU_SCAN: begin
        if (lru_done) state_nxt = found_r ? ST_FETCH : ST_EMIT;
      end
      ST_FETCH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory write on a page access
  assign acc_stamp = (mode_r == MODE_LRU) ? stamp_ctr_r : STAMP_W'(1);
  always_comb begin
    st_wr.we    = acc_go;
    st_wr.addr  = in_page_number;
    st_wr.stamp = acc_stamp;
    st_wr.frame = in_frame_number;
  end

  // Datapath next values
  always_comb begin
    present_nxt   = present_r;
    modified_nxt  = modified_r;
    sval_nxt      = sval_r;
    unz_nxt       = unz_r;
    hand_nxt      = hand_r;
    stamp_ctr_nxt = stamp_ctr_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    dly_vld_nxt   = 1'b0;
    dly_idx_nxt   = idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    victim_nxt    = victim_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_page_nxt  = out_page_r;
    out_frame_nxt = out_frame_r;
    out_dirty_nxt = out_dirty_r;
    out_nov_nxt   = out_nov_r;

    case (state_r)
      ST_IDLE: begin
        // Page access updates its state bits
        if (acc_go) begin
          present_nxt[in_page_number] = 1'b1;
          sval_nxt[in_page_number]    = 1'b1;
          unz_nxt[in_page_number]     = (acc_stamp != '0);
          if (in_is_write) modified_nxt[in_page_number] = 1'b1;
          if (mode_r == MODE_LRU) stamp_ctr_nxt = stamp_ctr_r + STAMP_W'(1);
        end
        // Victim request primes the scan
        if (vic_go) begin
          found_nxt = 1'b0;
          step_nxt  = '0;
          pass_nxt  = '0;
          idx_nxt   = (mode_r == MODE_LRU) ? '0 : hand_start;
        end
      end
      ST_CLK_SCAN: begin
        if (clk_hit) begin
          found_nxt  = 1'b1;
          victim_nxt = idx_r;
        end else begin
          // Second chance: clearing the use word is dropping its valid bit
          if (clk_clear) begin
            sval_nxt[idx_r] = 1'b0;
            unz_nxt[idx_r]  = 1'b0;
          end
          idx_nxt = idx_wrap ? '0 : idx_inc[PAGE_W-1:0];
          if (step_last) begin
            step_nxt = '0;
            pass_nxt = pass_r + 2'd1;
          end else begin
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      ST_LRU_SCAN: begin
        // Issue one read per cycle, compare the entry read the cycle before
        if (step_r != live_n) begin
          dly_vld_nxt = 1'b1;
          idx_nxt     = idx_inc[PAGE_W-1:0];
          step_nxt    = step_r + CNT_W'(1);
        end
        if (cand_better) begin
          found_nxt  = 1'b1;
          best_nxt   = cand_stamp;
          victim_nxt = dly_idx_r;
        end
      end
      ST_FETCH: begin
        // Frame memory read of the victim is in flight
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_nov_nxt   = ~found_r;
          out_page_nxt  = found_r ? victim_r : '0;
          out_frame_nxt = found_r ? frame_q : '0;
          out_dirty_nxt = found_r & modified_r[victim_r];
          if (found_r) begin
            present_nxt[victim_r]  = 1'b0;
            modified_nxt[victim_r] = 1'b0;
            if (mode_r == MODE_CLOCK) begin
              hand_nxt = (victim_inc == live_n) ? '0 : victim_inc[PAGE_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      modified_r  <= '0;
      sval_r      <= '0;
      unz_r       <= '0;
      hand_r      <= '0;
      stamp_ctr_r <= '0;
      dly_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      modified_r  <= modified_nxt;
      sval_r      <= sval_nxt;
      unz_r       <= unz_nxt;
      hand_r      <= hand_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      dly_vld_r   <= dly_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    step_r      <= step_nxt;
    pass_r      <= pass_nxt;
    dly_idx_r   <= dly_idx_nxt;
    best_r      <= best_nxt;
    victim_r    <= victim_nxt;
    out_page_r  <= out_page_nxt;
    out_frame_r <= out_frame_nxt;
    out_dirty_r <= out_dirty_nxt;
    out_nov_r   <= out_nov_nxt;
  end

  // Stamp and frame storage
  prp_store u_store (
    .clk         (clk),
    .wr          (st_wr),
    .stamp_raddr (idx_r),
    .frame_raddr (victim_r),
    .stamp_q     (stamp_q),
    .frame_q     (frame_q)
  );

  // Configuration port: write at the access beat, word address picks the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CLOCK;
      pages_r <= PAGES_CNT;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MODE:  mode_r  <= pwdata[0];
        REG_PAGES: pages_r <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = DATA_W'(mode_r);
      REG_PAGES: prdata = DATA_W'(pages_r);
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_victim_page  = out_page_r;
  assign out_victim_frame = out_frame_r;
  assign out_victim_dirty = out_dirty_r;
  assign out_no_victim    = out_nov_r;

  // A no-victim beat carries zero fields
  a_nov_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_victim) |->
      (out_victim_page == '0 && out_victim_frame == '0 && !out_victim_dirty))
    else $error("no-victim beat with nonzero fields");

  // The chosen victim is a present page
  a_victim_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> present_r[victim_r])
    else $error("victim page not present");

  // An emitted victim is evicted the next cycle
  a_victim_evicted: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && found_r) |=> !present_r[$past(victim_r)])
    else $error("victim still present after eviction");

  // The scan never runs while a request is taken
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLK_SCAN || state_r == ST_LRU_SCAN) |-> !in_ready)
    else $error("input accepted during a victim search");

endmodule

@@ dv/page_replacement_policy_checker.sv @@
// Checker for the page replacement block: tracks the page table, predicts victims, compares beats.
`timescale 1ns / 100ps

module page_replacement_policy_checker import prp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_kind,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_number,
  input  logic               in_is_write,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PAGE_W-1:0]  out_victim_page,
  input  logic [FRAME_W-1:0] out_victim_frame,
  input  logic               out_victim_dirty,
  input  logic               out_no_victim,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               dirty;
    logic               none;
  } victim_t;

  victim_t victim_q[$];

  // Shadow page table and policy state
  logic               present   [PAGES];
  logic               dirty_bit [PAGES];
  logic [STAMP_W-1:0] use_word  [PAGES];
  logic [FRAME_W-1:0] frame_of  [PAGES];
  int                 hand;
  logic [STAMP_W-1:0] stamp_ctr;
  logic               mode;
  logic [CNT_W-1:0]   pages_cfg;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Page count clamps at the table size
  function automatic int live_pages();
    return (int'(pages_cfg) > PAGES) ? PAGES : int'(pages_cfg);
  endfunction

  // LRU: smallest stamp, lowest index on a tie
  function automatic int oldest_page(input int n);
    int best;
    best = -1;
    for (int i = 0; i < n; i++) begin
      if (present[i] && (best < 0 || use_word[i] < use_word[best])) best = i;
    end
    return best;
  endfunction

  // Enhanced clock: clean pass, then dirty pass that clears use words, twice
  function automatic int sweep_clock(input int n);
    int start;
    int idx;
    start = (hand < n) ? hand : 0;
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < n; k++) begin
        idx = (start + k) % n;
        if (present[idx] && !dirty_bit[idx] && use_word[idx] == '0) return idx;
      end
      for (int k = 0; k < n; k++) begin
        idx = (start + k) % n;
        if (!present[idx]) continue;
        if (dirty_bit[idx] && use_word[idx] == '0) return idx;
        use_word[idx] = '0;
      end
    end
    return -1;
  endfunction

  function automatic void record_access(input logic [PAGE_W-1:0] page,
                                        input logic [FRAME_W-1:0] frame,
                                        input logic wr);
    int p;
    p = int'(page);
    if (p >= live_pages()) return;
    present[p]  = 1'b1;
    frame_of[p] = frame;
    if (wr) dirty_bit[p] = 1'b1;
    if (mode == MODE_LRU) begin
      use_word[p] = stamp_ctr;
      stamp_ctr   = stamp_ctr + 1'b1;
    end else begin
      use_word[p] = STAMP_W'(1);
    end
  endfunction

  function automatic victim_t evict_page();
    victim_t res;
    int n;
    int v;
    n = live_pages();
    v = -1;
    if (n > 0) v = (mode == MODE_LRU) ? oldest_page(n) : sweep_clock(n);
    res.page  = '0;
    res.frame = '0;
    res.dirty = 1'b0;
    res.none  = 1'b1;
    if (v >= 0) begin
      res.page     = PAGE_W'(v);
      res.frame    = frame_of[v];
      res.dirty    = dirty_bit[v];
      res.none     = 1'b0;
      present[v]   = 1'b0;
      dirty_bit[v] = 1'b0;
      if (mode == MODE_CLOCK) hand = (v + 1 == n) ? 0 : v + 1;
    end
    return res;
  endfunction

  // Watch config writes, result beats and input beats
  always @(posedge clk) begin
    victim_t want;
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) begin
        present[i]   = 1'b0;
        dirty_bit[i] = 1'b0;
        use_word[i]  = '0;
      end
      hand      = 0;
      stamp_ctr = '0;
      mode      = MODE_CLOCK;
      pages_cfg = PAGES_CNT;
      victim_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) mode = pwdata[0];
        else if (paddr[2] == REG_PAGES) pages_cfg = pwdata[CNT_W-1:0];
      end
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (victim_q.size() == 0) begin
          $error("result beat with no victim request outstanding");
          fail_count++;
        end else begin
          want = victim_q.pop_front();
          if (out_no_victim !== want.none) begin
            $error("no_victim: expected %0d, got %0d", want.none, out_no_victim);
            fail_count++;
          end
          if (out_victim_page !== want.page) begin
            $error("victim_page: expected %0d, got %0d", want.page, out_victim_page);
            fail_count++;
          end
          if (out_victim_frame !== want.frame) begin
            $error("victim_frame: expected %0d, got %0d", want.frame, out_victim_frame);
            fail_count++;
          end
          if (out_victim_dirty !== want.dirty) begin
            $error("victim_dirty: expected %0d, got %0d", want.dirty, out_victim_dirty);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_VICTIM) victim_q.push_back(evict_page());
        else record_access(in_page_number, in_frame_number, in_is_write);
      end
    end
    pending = victim_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the page replacement block: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps

module testbench;
  import prp_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MODE  = ADDR_W'(4 * REG_MODE);
  localparam logic [ADDR_W-1:0] ADDR_PAGES = ADDR_W'(4 * REG_PAGES);
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [PAGE_W-1:0]  in_page_number;
  logic [FRAME_W-1:0] in_frame_number;
  logic               in_is_write;
  logic               out_valid;
  logic               out_ready;
  logic [PAGE_W-1:0]  out_victim_page;
  logic [FRAME_W-1:0] out_victim_frame;
  logic               out_victim_dirty;
  logic               out_no_victim;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  logic allow_gaps;
  logic hold_phase;
  logic hold_done;
  int   quiet_cycles;
  int   live_span;

  page_replacement_policy_top dut (.*);
  page_replacement_policy_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender side: geometric gaps with valid low, then hold until the beat lands
  task automatic send_item(input logic kind, input logic [PAGE_W-1:0] page,
                           input logic [FRAME_W-1:0] frame, input logic wr);
    while (allow_gaps && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_kind         = kind;
    in_page_number  = page;
    in_frame_number = frame;
    in_is_write     = wr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_access(input logic [PAGE_W-1:0] page,
                             input logic [FRAME_W-1:0] frame, input logic wr);
    send_item(KIND_ACCESS, page, frame, wr);
  endtask

  // victim request with junk in the unused fields
  task automatic send_victim();
    send_item(KIND_VICTIM, PAGE_W'($urandom), FRAME_W'($urandom), 1'($urandom));
  endtask

  // Drain all results, then let a trailing access finish
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_pages(input int count);
    reg_write(ADDR_PAGES, DATA_W'(count));
    live_span = (count > PAGES) ? PAGES : count;
  endtask

  // Receiver side: random stalls, plus one long hold-off
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready = !(allow_gaps && $urandom_range(99) < 19);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic mode_sel;
    int   count;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ACCESS;
    in_page_number  = '0;
    in_frame_number = '0;
    in_is_write     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    allow_gaps      = 1'b1;
    hold_phase      = 1'b0;
    quiet_cycles    = 0;
    live_span       = PAGES;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty table, then clock mode with both passes
    send_victim();
    send_access(6'd0, 8'd0, 1'b0);
    send_access(6'd63, 8'd255, 1'b1);
    send_access(6'd5, 8'hA5, 1'b1);
    send_access(6'd20, 8'h3C, 1'b0);
    send_victim();
    send_victim();

    // LRU with an oversized page count; pages 5 and 10 tie on stamp zero
    settle();
    reg_write(ADDR_MODE, DATA_W'(MODE_LRU));
    set_pages(127);
    send_access(6'd10, 8'd1, 1'b0);
    send_access(6'd3, 8'd2, 1'b1);
    send_access(6'd63, 8'hFF, 1'b1);
    send_victim();
    send_victim();

    // Clock over four pages: hand beyond range, old stamps as use bits
    settle();
    reg_write(ADDR_MODE, DATA_W'(MODE_CLOCK));
    set_pages(4);
    send_access(6'd40, 8'h11, 1'b1);
    send_access(6'd2, 8'h7E, 1'b1);
    send_victim();
    send_victim();
    send_victim();

    // No pages owned
    settle();
    set_pages(0);
    send_access(6'd0, 8'h55, 1'b0);
    send_victim();

    // Full table again, then a single page
    settle();
    set_pages(PAGES);
    send_victim();
    settle();
    set_pages(1);
    send_access(6'd0, 8'hC3, 1'b1);
    send_victim();

    // Random phases: mostly in-range accesses with victim requests mixed in
    for (int p = 0; p < PHASES; p++) begin
      settle();
      mode_sel = (p % 2 == 0) ? MODE_LRU : MODE_CLOCK;
      case ($urandom_range(9))
        0: count = $urandom_range(65, 127);
        1: count = PAGES;
        2: count = 1;
        default: count = $urandom_range(2, 63);
      endcase
      if (p == PHASES - 1) count = PAGES;
      reg_write(ADDR_MODE, DATA_W'(mode_sel));
      set_pages(count);
      allow_gaps = (p != 3);
      hold_phase = (p == 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 35) begin
          send_victim();
        end else if ($urandom_range(99) < 90) begin
          send_access(PAGE_W'($urandom_range(live_span - 1)), FRAME_W'($urandom),
                      1'($urandom));
        end else begin
          send_access(PAGE_W'($urandom), FRAME_W'($urandom), 1'($urandom));
        end
      end
      hold_phase = 1'b0;
    end

    // Drain and give the block time to show any stray result
    allow_gaps = 1'b1;
    in_valid   = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/prp_pkg.sv
design/prp_store.sv
design/page_replacement_policy_top.sv
dv/page_replacement_policy_checker.sv
dv/testbench.sv
